### rtl/jms_pkg.sv
// ----------------------------------------------------------------------------
// jms_pkg
// Shared types and marker codes for the JPEG metadata segment stripper.
// ----------------------------------------------------------------------------
package jms_pkg;

    // Marker codes
    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_EOI    = 8'hD9;
    localparam logic [7:0] MARK_RST0   = 8'hD0;
    localparam logic [7:0] MARK_RST7   = 8'hD7;
    localparam logic [7:0] MARK_TEM    = 8'h01;
    localparam logic [7:0] MARK_APP0   = 8'hE0;
    localparam logic [7:0] MARK_APP15  = 8'hEF;
    localparam logic [7:0] MARK_COM    = 8'hFE;
    localparam logic [7:0] MARK_SOS    = 8'hDA;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       out_last;
        logic       rejected;
    } item_t;

    // Work for the back part: one or two items from one input byte
    typedef struct packed {
        logic  two;
        item_t first;
        item_t second;
    } cmd_t;

    localparam item_t ITEM_NONE = '{out_byte: 8'h00, byte_valid: 1'b0,
                                    out_last: 1'b0, rejected: 1'b0};

    function automatic item_t data_item(input logic [7:0] b);
        item_t it;
        it = ITEM_NONE;
        it.out_byte   = b;
        it.byte_valid = 1'b1;
        return it;
    endfunction

endpackage

### rtl/jms_front.sv
// ----------------------------------------------------------------------------
// jms_front
// Byte parser: tracks the marker/segment phase and turns each byte into
// zero, one or two result items for the back part.
// ----------------------------------------------------------------------------
module jms_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    data_byte,
    input  logic          end_of_file,
    output logic          cmd_write,
    output jms_pkg::cmd_t cmd
);
    import jms_pkg::*;

    localparam logic [3:0] PH_START0 = 4'd0;
    localparam logic [3:0] PH_START1 = 4'd1;
    localparam logic [3:0] PH_MARK0  = 4'd2;
    localparam logic [3:0] PH_MARK1  = 4'd3;
    localparam logic [3:0] PH_LEN0   = 4'd4;
    localparam logic [3:0] PH_LEN1   = 4'd5;
    localparam logic [3:0] PH_BODY   = 4'd6;
    localparam logic [3:0] PH_COPY   = 4'd7;
    localparam logic [3:0] PH_DROP   = 4'd8;
    localparam logic [3:0] PH_REJECT = 4'd9;

    logic [3:0]  phase_reg,      phase_next;
    logic [7:0]  held_code_reg,  held_code_next;
    logic        keep_reg,       keep_next;
    logic        scan_reg,       scan_next;
    logic [7:0]  len_high_reg,   len_high_next;
    logic [15:0] bytes_left_reg, bytes_left_next;

    logic [1:0]  cnt;
    item_t       item0;
    item_t       item1;
    logic [15:0] seg_len;
    logic [15:0] left_dec;

    always_comb
    begin
        phase_next      = phase_reg;
        held_code_next  = held_code_reg;
        keep_next       = keep_reg;
        scan_next       = scan_reg;
        len_high_next   = len_high_reg;
        bytes_left_next = bytes_left_reg;
        cnt             = 2'd0;
        item0           = ITEM_NONE;
        item1           = ITEM_NONE;
        seg_len         = {len_high_reg, data_byte};
        left_dec        = (bytes_left_reg != 16'd0) ? bytes_left_reg - 16'd1 : 16'd0;

        case (phase_reg)
            PH_START0:
            begin
                if (data_byte != MARK_PREFIX || end_of_file)
                begin
                    item0.out_last = 1'b1;
                    item0.rejected = 1'b1;
                    cnt            = 2'd1;
                    phase_next     = PH_REJECT;
                end
                else
                begin
                    phase_next = PH_START1;
                end
            end
            PH_START1:
            begin
                if (data_byte != MARK_SOI)
                begin
                    item0.out_last = 1'b1;
                    item0.rejected = 1'b1;
                    cnt            = 2'd1;
                    phase_next     = PH_REJECT;
                end
                else
                begin
                    item0      = data_item(MARK_PREFIX);
                    item1      = data_item(MARK_SOI);
                    cnt        = 2'd2;
                    phase_next = PH_MARK0;
                end
            end
            PH_MARK0:
            begin
                if (data_byte != MARK_PREFIX)
                begin
                    item0      = data_item(data_byte);
                    cnt        = 2'd1;
                    phase_next = PH_COPY;
                end
                else
                begin
                    phase_next = PH_MARK1;
                end
            end
            PH_MARK1:
            begin
                if (data_byte == MARK_EOI)
                begin
                    item0      = data_item(MARK_PREFIX);
                    item1      = data_item(MARK_EOI);
                    cnt        = 2'd2;
                    phase_next = PH_DROP;
                end
                else if (data_byte inside {[MARK_RST0:MARK_RST7], MARK_TEM})
                begin
                    item0      = data_item(MARK_PREFIX);
                    item1      = data_item(data_byte);
                    cnt        = 2'd2;
                    phase_next = PH_MARK0;
                end
                else
                begin
                    held_code_next = data_byte;
                    keep_next      = !(data_byte inside {[MARK_APP0:MARK_APP15], MARK_COM});
                    scan_next      = (data_byte == MARK_SOS);
                    phase_next     = PH_LEN0;
                end
            end
            PH_LEN0:
            begin
                len_high_next = data_byte;
                if (keep_reg && !end_of_file)
                begin
                    item0 = data_item(MARK_PREFIX);
                    item1 = data_item(held_code_reg);
                    cnt   = 2'd2;
                end
                phase_next = PH_LEN1;
            end
            PH_LEN1:
            begin
                if (seg_len < 16'd2)
                begin
                    seg_len = 16'd2;
                end
                bytes_left_next = seg_len - 16'd2;
                if (keep_reg)
                begin
                    item0 = data_item(len_high_reg);
                    item1 = data_item(data_byte);
                    cnt   = 2'd2;
                end
                if (scan_reg)
                begin
                    phase_next = PH_COPY;
                end
                else if (bytes_left_next == 16'd0)
                begin
                    phase_next = PH_MARK0;
                end
                else
                begin
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (keep_reg)
                begin
                    item0 = data_item(data_byte);
                    cnt   = 2'd1;
                end
                bytes_left_next = left_dec;
                if (left_dec == 16'd0)
                begin
                    phase_next = PH_MARK0;
                end
            end
            PH_COPY:
            begin
                item0 = data_item(data_byte);
                cnt   = 2'd1;
            end
            default:
            begin
                // drop after EOI, or a rejected file: emit nothing
            end
        endcase

        if (end_of_file)
        begin
            case (cnt)
                2'd0:
                begin
                    if (phase_reg != PH_REJECT)
                    begin
                        item0          = ITEM_NONE;
                        item0.out_last = 1'b1;
                        cnt            = 2'd1;
                    end
                end
                2'd1:    item0.out_last = 1'b1;
                default: item1.out_last = 1'b1;
            endcase
            // return to the reset state for the next file
            phase_next      = PH_START0;
            held_code_next  = 8'h00;
            keep_next       = 1'b0;
            scan_next       = 1'b0;
            len_high_next   = 8'h00;
            bytes_left_next = 16'd0;
        end
    end

    assign cmd_write  = accept && (cnt != 2'd0);
    assign cmd.two    = (cnt == 2'd2);
    assign cmd.first  = item0;
    assign cmd.second = item1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START0;
            held_code_reg  <= 8'h00;
            keep_reg       <= 1'b0;
            scan_reg       <= 1'b0;
            len_high_reg   <= 8'h00;
            bytes_left_reg <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            held_code_reg  <= held_code_next;
            keep_reg       <= keep_next;
            scan_reg       <= scan_next;
            len_high_reg   <= len_high_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

### rtl/jms_queue.sv
// ----------------------------------------------------------------------------
// jms_queue
// Short FIFO of parser commands between the front and back parts.
// ----------------------------------------------------------------------------
module jms_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  jms_pkg::cmd_t wr_cmd,
    output logic          q_full,
    input  logic          rd_en,
    output jms_pkg::cmd_t rd_cmd,
    output logic          q_empty
);
    import jms_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr;
    logic          do_rd;

    assign q_full  = (count_reg == FULL_CNT);
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_cmd  = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = do_wr ? ((wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1) : wptr_reg;
        rptr_next  = do_rd ? ((rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1) : rptr_reg;
        count_next = count_reg + CW'(do_wr) - CW'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/jms_back.sv
// ----------------------------------------------------------------------------
// jms_back
// Result sequencer: unpacks one- or two-item commands into the output
// register, one item per cycle while that register is free or being popped.
// ----------------------------------------------------------------------------
module jms_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  jms_pkg::cmd_t rd_cmd,
    output logic          rd_en,
    output jms_pkg::item_t out_item,
    output logic          out_empty,
    input  logic          out_pop
);
    import jms_pkg::*;

    item_t out_reg;
    logic  out_full_reg;
    item_t second_reg;
    logic  second_pend_reg;
    logic  slot_free;

    assign slot_free = !out_full_reg || out_pop;
    assign rd_en     = slot_free && !second_pend_reg && !q_empty;
    assign out_item  = out_reg;
    assign out_empty = !out_full_reg;

    always_ff @(posedge clk)
    begin
        if (slot_free && second_pend_reg)
        begin
            out_reg <= second_reg;
        end
        else if (rd_en)
        begin
            out_reg    <= rd_cmd.first;
            second_reg <= rd_cmd.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg    <= 1'b0;
            second_pend_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            if (second_pend_reg)
            begin
                out_full_reg    <= 1'b1;
                second_pend_reg <= 1'b0;
            end
            else
            begin
                out_full_reg    <= !q_empty;
                second_pend_reg <= !q_empty && rd_cmd.two;
            end
        end
    end

endmodule

### rtl/jpeg_metadata_segment_stripper.sv
// ----------------------------------------------------------------------------
// jpeg_metadata_segment_stripper
// Streams a JPEG file byte by byte and removes APPn and COM segments.
// ----------------------------------------------------------------------------
// Push one file byte per item (end_of_file marks the last one) and pop the
// cleaned bytes from the result side. The front parser takes one byte per
// clock while full is low; each byte yields zero, one or two result items
// (a marker pair such as FF D8 gives two), packed into one command in a
// QUEUE_DEPTH-entry queue. The back sequencer moves one item per clock into
// the output register while it is free or being popped, so a byte that
// yields a pair takes the output register twice; the output register is
// the limit. A file not starting with FF D8 gives one item with
// rejected=1 and out_last=1 and nothing else. When the final byte yields no
// data, an empty item (byte_valid=0, out_last=1) closes the file. Files may
// follow each other directly; the parser rearms after every end_of_file.
// ----------------------------------------------------------------------------
module jpeg_metadata_segment_stripper
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       end_of_file,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       out_last,
    output logic       rejected
);
    import jms_pkg::*;

    logic  accept;
    logic  cmd_write;
    cmd_t  wr_cmd;
    cmd_t  rd_cmd;
    logic  q_full;
    logic  q_empty;
    logic  rd_en;
    item_t out_item;

    // take a byte whenever the command queue has room
    assign full   = q_full;
    assign accept = push && !q_full;

    jms_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .end_of_file (end_of_file),
        .cmd_write   (cmd_write),
        .cmd         (wr_cmd)
    );

    jms_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_write),
        .wr_cmd  (wr_cmd),
        .q_full  (q_full),
        .rd_en   (rd_en),
        .rd_cmd  (rd_cmd),
        .q_empty (q_empty)
    );

    jms_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .rd_cmd    (rd_cmd),
        .rd_en     (rd_en),
        .out_item  (out_item),
        .out_empty (empty),
        .out_pop   (pop)
    );

    // present the head result item field by field
    assign out_byte   = out_item.out_byte;
    assign byte_valid = out_item.byte_valid;
    assign out_last   = out_item.out_last;
    assign rejected   = out_item.rejected;

endmodule

### rtl/jms_checker.sv
// ----------------------------------------------------------------------------
// jms_checker
// Port-level checks on the result stream of the metadata stripper.
// ----------------------------------------------------------------------------
module jms_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       out_last,
    input logic       rejected
);

    // hold a waiting item until it is taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_byte) && $stable(out_last))
        else $error("result item changed while stalled");

    // empty items only ever close a file
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !byte_valid |-> out_last)
        else $error("empty item without last mark");

    // an item without data carries a zero byte
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !byte_valid |-> out_byte == 8'h00)
        else $error("empty item with nonzero byte");

    // a rejected item is an empty last item
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && rejected |-> out_last && !byte_valid)
        else $error("malformed rejected item");

endmodule

bind jpeg_metadata_segment_stripper jms_checker u_jms_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .out_last   (out_last),
    .rejected   (rejected)
);

### tb/sv/tb_jpeg_metadata_segment_stripper.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_jpeg_metadata_segment_stripper
// Self-checking bench for the JPEG APPn/COM segment stripper. Whole files are
// pushed one byte per item; a software copy of the parser builds the
// expected cleaned stream, and every popped item is checked field by field.
// ----------------------------------------------------------------------------
module tb_jpeg_metadata_segment_stripper;

    import jms_pkg::*;

    // Run control
    localparam int CYCLE_LIMIT  = 400000;
    localparam int GAP_MAX      = 13;
    localparam int RANDOM_BYTES = 1650;
    localparam int DRAIN_CYCLES = 20;
    localparam int FULL_HOLD    = 80;

    // Segment codes that are not in the package; all of them carry a length
    // and must pass through whole.
    localparam logic [7:0] MARK_SOF0 = 8'hC0;
    localparam logic [7:0] MARK_DHT  = 8'hC4;
    localparam logic [7:0] MARK_DQT  = 8'hDB;
    localparam logic [7:0] MARK_DRI  = 8'hDD;

    // Parser position inside the file, one step per byte
    typedef enum logic [3:0] {
        PH_SOI_FF,
        PH_SOI_CODE,
        PH_MARK_FF,
        PH_MARK_CODE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY,
        PH_COPY,
        PH_DROP,
        PH_REJECT
    } parse_phase_e;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       push        = 1'b0;
    logic [7:0] data_byte   = 8'h00;
    logic       end_of_file = 1'b0;
    logic       pop         = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
    logic       rejected;

    // Software copy of the parser state
    parse_phase_e parse_phase  = PH_SOI_FF;
    logic [7:0]   held_code    = 8'h00;
    logic         keep_segment = 1'b0;
    logic         scan_start   = 1'b0;
    logic [7:0]   len_high     = 8'h00;
    logic [15:0]  body_left    = 16'h0000;

    // Cleaned items still owed by the block, oldest first
    item_t      cleaned_q[$];
    // File under construction, sent byte by byte
    logic [7:0] file_bytes[$];

    int tx_gap_max     = GAP_MAX;
    int rx_gap_max     = GAP_MAX;
    int rx_hold_cycles = 0;
    int err_count      = 0;
    int bytes_sent     = 0;
    int cycle_count    = 0;

    always #1 clk = ~clk;

    jpeg_metadata_segment_stripper dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .end_of_file (end_of_file),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .out_last    (out_last),
        .rejected    (rejected)
    );

    // ------------------------------------------------------------------------
    // Expected-stream builder
    // ------------------------------------------------------------------------

    function automatic item_t result_item(input logic [7:0] b, input logic valid,
                                          input logic last, input logic rej);
        item_t it;
        it.out_byte   = valid ? b : 8'h00;
        it.byte_valid = valid;
        it.out_last   = last;
        it.rejected   = rej;
        return it;
    endfunction

    // Rearm for the next file
    function automatic void rearm_parser();
        parse_phase  = PH_SOI_FF;
        held_code    = 8'h00;
        keep_segment = 1'b0;
        scan_start   = 1'b0;
        len_high     = 8'h00;
        body_left    = 16'h0000;
    endfunction

    // Advance the parser by one accepted byte and queue the items it yields
    function automatic void strip_byte(input logic [7:0] b, input logic eof);
        item_t        step_q[$];
        item_t        closing;
        parse_phase_e entry;
        logic [15:0]  seg_len;
        entry = parse_phase;
        case (parse_phase)
            PH_SOI_FF:
            begin
                // A file that is not FF D8, or ends on its first byte, is rejected
                if (b != MARK_PREFIX || eof)
                begin
                    step_q.push_back(result_item(8'h00, 1'b0, 1'b1, 1'b1));
                    parse_phase = PH_REJECT;
                end
                else
                begin
                    parse_phase = PH_SOI_CODE;
                end
            end
            PH_SOI_CODE:
            begin
                if (b != MARK_SOI)
                begin
                    step_q.push_back(result_item(8'h00, 1'b0, 1'b1, 1'b1));
                    parse_phase = PH_REJECT;
                end
                else
                begin
                    step_q.push_back(result_item(MARK_PREFIX, 1'b1, 1'b0, 1'b0));
                    step_q.push_back(result_item(MARK_SOI, 1'b1, 1'b0, 1'b0));
                    parse_phase = PH_MARK_FF;
                end
            end
            PH_MARK_FF:
            begin
                // Anything but a marker prefix here turns the rest into raw copy
                if (b != MARK_PREFIX)
                begin
                    step_q.push_back(result_item(b, 1'b1, 1'b0, 1'b0));
                    parse_phase = PH_COPY;
                end
                else
                begin
                    parse_phase = PH_MARK_CODE;
                end
            end
            PH_MARK_CODE:
            begin
                if (b == MARK_EOI)
                begin
                    step_q.push_back(result_item(MARK_PREFIX, 1'b1, 1'b0, 1'b0));
                    step_q.push_back(result_item(MARK_EOI, 1'b1, 1'b0, 1'b0));
                    parse_phase = PH_DROP;
                end
                else if ((b >= MARK_RST0 && b <= MARK_RST7) || b == MARK_TEM)
                begin
                    step_q.push_back(result_item(MARK_PREFIX, 1'b1, 1'b0, 1'b0));
                    step_q.push_back(result_item(b, 1'b1, 1'b0, 1'b0));
                    parse_phase = PH_MARK_FF;
                end
                else
                begin
                    // Hold the code until the length proves the marker complete
                    held_code    = b;
                    keep_segment = !((b >= MARK_APP0 && b <= MARK_APP15) || b == MARK_COM);
                    scan_start   = (b == MARK_SOS);
                    parse_phase  = PH_LEN_HI;
                end
            end
            PH_LEN_HI:
            begin
                len_high = b;
                // A marker cut off after its first length byte is dropped
                if (keep_segment && !eof)
                begin
                    step_q.push_back(result_item(MARK_PREFIX, 1'b1, 1'b0, 1'b0));
                    step_q.push_back(result_item(held_code, 1'b1, 1'b0, 1'b0));
                end
                parse_phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                // Clamp short lengths to the two length bytes themselves
                seg_len = {len_high, b};
                if (seg_len < 16'd2)
                    seg_len = 16'd2;
                body_left = seg_len - 16'd2;
                if (keep_segment)
                begin
                    step_q.push_back(result_item(len_high, 1'b1, 1'b0, 1'b0));
                    step_q.push_back(result_item(b, 1'b1, 1'b0, 1'b0));
                end
                if (scan_start)
                    parse_phase = PH_COPY;
                else if (body_left == 16'd0)
                    parse_phase = PH_MARK_FF;
                else
                    parse_phase = PH_BODY;
            end
            PH_BODY:
            begin
                if (keep_segment)
                    step_q.push_back(result_item(b, 1'b1, 1'b0, 1'b0));
                if (body_left != 16'd0)
                    body_left = body_left - 16'd1;
                if (body_left == 16'd0)
                    parse_phase = PH_MARK_FF;
            end
            PH_COPY:
            begin
                step_q.push_back(result_item(b, 1'b1, 1'b0, 1'b0));
            end
            default:
            begin
                // After EOI or a rejected start: drop everything
            end
        endcase

        if (eof)
        begin
            // Close the file: mark the last item, or add an empty one when the
            // final byte yields nothing (never after a rejected start)
            if (step_q.size() == 0)
            begin
                if (entry != PH_REJECT)
                    step_q.push_back(result_item(8'h00, 1'b0, 1'b1, 1'b0));
            end
            else
            begin
                closing          = step_q.pop_back();
                closing.out_last = 1'b1;
                step_q.push_back(closing);
            end
            rearm_parser();
        end

        foreach (step_q[i])
            cleaned_q.push_back(step_q[i]);
    endfunction

    // ------------------------------------------------------------------------
    // File construction
    // ------------------------------------------------------------------------

    function automatic void add_marker(input logic [7:0] code);
        file_bytes.push_back(MARK_PREFIX);
        file_bytes.push_back(code);
    endfunction

    function automatic void add_random(input int count);
        repeat (count)
            file_bytes.push_back(8'($urandom_range(255)));
    endfunction

    // Append a marker with a correct length and a random body
    function automatic void add_segment(input logic [7:0] code, input int body_len);
        logic [15:0] seg_len;
        seg_len = 16'(body_len + 2);
        add_marker(code);
        file_bytes.push_back(seg_len[15:8]);
        file_bytes.push_back(seg_len[7:0]);
        add_random(body_len);
    endfunction

    function automatic logic [7:0] kept_code();
        case ($urandom_range(3))
            0:       return MARK_SOF0;
            1:       return MARK_DHT;
            2:       return MARK_DQT;
            default: return MARK_DRI;
        endcase
    endfunction

    // Any code that takes a length: stripped or kept
    function automatic logic [7:0] length_code();
        case ($urandom_range(2))
            0:       return MARK_APP0 + 8'($urandom_range(15));
            1:       return MARK_COM;
            default: return kept_code();
        endcase
    endfunction

    // Mostly well-formed files with random content, some noise, some cut short
    function automatic void build_random_file();
        int kind;
        int pick;
        int cut;
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            // Noise: random bytes, in half of these files led by a good prefix byte
            add_random($urandom_range(6, 1));
            if (kind < 4)
                file_bytes[0] = MARK_PREFIX;
            return;
        end

        add_marker(MARK_SOI);
        repeat ($urandom_range(4))
        begin
            pick = $urandom_range(9);
            case (pick)
                0, 1, 2: add_segment(MARK_APP0 + 8'($urandom_range(15)), $urandom_range(5));
                3:       add_segment(MARK_COM, $urandom_range(5));
                4, 5:    add_segment(kept_code(), $urandom_range(5));
                6:
                begin
                    if ($urandom_range(8) == 8)
                        add_marker(MARK_TEM);
                    else
                        add_marker(MARK_RST0 + 8'($urandom_range(7)));
                end
                7:
                begin
                    // Length of 0 or 1
                    add_marker(length_code());
                    file_bytes.push_back(8'h00);
                    file_bytes.push_back(8'($urandom_range(1)));
                end
                8:       add_segment(MARK_PREFIX, $urandom_range(3));
                default: add_segment(8'($urandom_range(255)), $urandom_range(5));
            endcase
        end

        pick = $urandom_range(9);
        case (pick)
            0, 1, 2, 3:
            begin
                // Scan: everything after the header is copied
                add_segment(MARK_SOS, $urandom_range(3));
                add_random($urandom_range(10, 1));
            end
            4, 5:
            begin
                add_marker(MARK_EOI);
                add_random($urandom_range(3));
            end
            6:
            begin
                // Stray byte where a marker belongs
                file_bytes.push_back(8'($urandom_range(254)));
                add_random($urandom_range(4));
            end
            7:
            begin
                // Random 16-bit length and up to three more bytes, so the file mostly ends inside the body
                add_marker(length_code());
                add_random(2 + $urandom_range(3));
            end
            default:
            begin
                // End right after the last segment
            end
        endcase

        // Cut some files at a random point to hit truncated markers
        if (kind < 25)
        begin
            cut = $urandom_range(file_bytes.size(), 1);
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offer one byte after a random gap; hold push high so back-to-back bytes
    // need no extra edge. Caller is always at a rising edge.
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        gap = $urandom_range(tx_gap_max);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        data_byte   <= b;
        end_of_file <= eof;
        @(posedge clk);
        while (full)
            @(posedge clk);
        strip_byte(b, eof);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    // Drop push and wait until every owed item has been popped
    task automatic pause_sender();
        push <= 1'b0;
        @(posedge clk);
        while (cleaned_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // APPn and COM vanish; a short-length kept segment, RST and TEM pass;
    // EOI passes and the trailing byte yields only the empty closing item.
    task automatic test_segment_filter();
        file_bytes = '{MARK_PREFIX, MARK_SOI,
                       MARK_PREFIX, MARK_APP0, 8'h00, 8'h02,
                       MARK_PREFIX, MARK_COM, 8'h00, 8'h03, 8'hAA,
                       MARK_PREFIX, MARK_DQT, 8'h00, 8'h01,
                       MARK_PREFIX, MARK_RST0, MARK_PREFIX, MARK_TEM,
                       MARK_PREFIX, MARK_RST7, MARK_PREFIX, MARK_EOI, 8'h00};
        send_file();
    endtask

    // Wrong first byte, a file of one prefix byte, wrong second byte
    task automatic test_bad_start();
        file_bytes = '{8'h00};
        send_file();
        file_bytes = '{MARK_PREFIX};
        send_file();
        file_bytes = '{MARK_PREFIX, 8'h00, 8'h5A};
        send_file();
    endtask

    // Files ending after a prefix, after the first length byte, and after a
    // zero length of a stripped segment (nothing to emit at the end)
    task automatic test_cut_off_marker();
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX};
        send_file();
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_DQT, 8'h00};
        send_file();
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_APP15, 8'h00, 8'h00};
        send_file();
    endtask

    // Code FF with zero length, then SOS: the EOI after it is plain data
    task automatic test_scan_copy();
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_PREFIX, 8'h00, 8'h00,
                       MARK_PREFIX, MARK_SOS, 8'h00, 8'h02, MARK_PREFIX, MARK_EOI};
        send_file();
    endtask

    // A non-prefix byte right after SOI switches to raw copy
    task automatic test_stray_byte();
        file_bytes = '{MARK_PREFIX, MARK_SOI, 8'h80, 8'h7F};
        send_file();
    endtask

    // Stall the receiver for a long stretch while bytes stream in at full
    // rate, so the internal queue fills and full pushes back
    task automatic test_backpressure();
        tx_gap_max     = 0;
        rx_hold_cycles = FULL_HOLD;
        add_marker(MARK_SOI);
        add_segment(MARK_DQT, 6);
        add_segment(MARK_SOS, 0);
        add_random(30);
        send_file();
        tx_gap_max = GAP_MAX;
        pause_sender();
    endtask

    // Random files; idle pattern changes per file, with full-rate stretches
    task automatic test_random_files();
        int first_byte;
        int files;
        first_byte = bytes_sent;
        files      = 0;
        while (bytes_sent - first_byte < RANDOM_BYTES)
        begin
            case ($urandom_range(9))
                0:       begin tx_gap_max = 0;       rx_gap_max = GAP_MAX; end
                1:       begin tx_gap_max = GAP_MAX; rx_gap_max = 0;       end
                2:       begin tx_gap_max = 0;       rx_gap_max = 0;       end
                default: begin tx_gap_max = GAP_MAX; rx_gap_max = GAP_MAX; end
            endcase
            build_random_file();
            send_file();
            files++;
            // Let the block run dry now and then
            if (files % 16 == 0)
                pause_sender();
        end
        tx_gap_max = GAP_MAX;
        rx_gap_max = GAP_MAX;
    endtask

    // ------------------------------------------------------------------------
    // Result checker: pop with random gaps, compare against the oldest owed
    // item. A long hold requested by a test is counted here.
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            err_count++;
        end
    endfunction

    initial
    begin : result_checker
        int    hold;
        item_t want;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
                hold = rx_hold_cycles;
            else
                hold = $urandom_range(rx_gap_max);
            rx_hold_cycles = 0;
            if (hold > 0)
            begin
                pop <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            if (cleaned_q.size() == 0)
            begin
                $error("unexpected item: out_byte %h byte_valid %b out_last %b rejected %b",
                       out_byte, byte_valid, out_last, rejected);
                err_count++;
            end
            else
            begin
                want = cleaned_q.pop_front();
                check_field("out_byte", want.out_byte, out_byte);
                check_field("byte_valid", 8'(want.byte_valid), 8'(byte_valid));
                check_field("out_last", 8'(want.out_last), 8'(out_last));
                check_field("rejected", 8'(want.rejected), 8'(rejected));
            end
        end
    end

    // Hard stop for a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_jpeg_metadata_segment_stripper: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_segment_filter();
        test_bad_start();
        test_cut_off_marker();
        test_scan_copy();
        test_stray_byte();
        test_backpressure();
        test_random_files();

        // Drain, then give the pipeline time to show any stray item
        pause_sender();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb_jpeg_metadata_segment_stripper: clean");
        else
            $display("tb_jpeg_metadata_segment_stripper: errors");
        $finish;
    end

endmodule
